// ===== hdl/range_scan_object_segmenter_assert.svh =====
// ---------------------------------------------------------------------------
// Range scan object segmenter: assertion macros
// Shared property templates, clocked on aclk and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef RANGE_SCAN_OBJECT_SEGMENTER_ASSERT_SVH
`define RANGE_SCAN_OBJECT_SEGMENTER_ASSERT_SVH

// Same-cycle implication
`define RSOS_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define RSOS_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/rsos_pkg.sv =====
// ---------------------------------------------------------------------------
// rsos_pkg
// Types, register map and constants of the range scan object segmenter.
// ---------------------------------------------------------------------------
package rsos_pkg;

    // Field widths
    localparam int SAMPLE_W   = 12;
    localparam int ANGLE_W    = 9;
    localparam int SPAN_W     = 7;
    localparam int RATIO_W    = 4;
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_SCAN_SPAN  = 3'd0;
    localparam logic [2:0] REG_FAR_LIMIT  = 3'd1;
    localparam logic [2:0] REG_SPIKE      = 3'd2;
    localparam logic [2:0] REG_DROP_RATIO = 3'd3;
    localparam logic [2:0] REG_MARGIN     = 3'd4;
    localparam logic [2:0] REG_HEADING    = 3'd5;

    // Register reset values
    localparam logic [SPAN_W-1:0]   RST_SCAN_SPAN  = 7'd90;
    localparam logic [SAMPLE_W-1:0] RST_FAR_LIMIT  = 12'd100;
    localparam logic [SAMPLE_W-1:0] RST_SPIKE      = 12'd30;
    localparam logic [RATIO_W-1:0]  RST_DROP_RATIO = 4'd7;
    localparam logic [SAMPLE_W-1:0] RST_MARGIN     = 12'd15;
    localparam logic [ANGLE_W-1:0]  RST_HEADING    = 9'd90;

    // Arithmetic constants
    localparam int                  DEG_FULL    = 360;
    localparam logic [ANGLE_W-1:0]  ANGLE_LIMIT = 9'd360;
    localparam logic [12:0]         EDGE_PAD_CM = 13'd50;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX  = 12'hFFF;

    typedef struct packed {
        logic [SPAN_W-1:0]   scan_span;
        logic [SAMPLE_W-1:0] far_limit_cm;
        logic [SAMPLE_W-1:0] spike_cm;
        logic [RATIO_W-1:0]  drop_ratio_tenths;
        logic [SAMPLE_W-1:0] merge_margin_cm;
        logic [ANGLE_W-1:0]  heading_deg;
    } rsos_cfg_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_EDGE,
        ST_SPK_CUR,
        ST_SPK_CHK,
        ST_SPK_EX,
        ST_DET_INIT,
        ST_DET_CUR,
        ST_DET_CHK,
        ST_DET_ADV,
        ST_RUN_CHK,
        ST_RUN_EX,
        ST_MID,
        ST_MID_CAP,
        ST_EMIT_RD,
        ST_EMIT_LD
    } rsos_state_t;

    // Datapath commands, one per controller state
    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LOAD,
        OP_EDGE,
        OP_SPK_CUR,
        OP_SPK_RD,
        OP_SPK_EX,
        OP_DET_INIT,
        OP_DET_CUR,
        OP_DET_CHK,
        OP_DET_ADV,
        OP_RUN_CHK,
        OP_RUN_EX,
        OP_MID,
        OP_MID_CAP,
        OP_EMIT_LD
    } rsos_op_t;

    typedef struct packed {
        logic final_fire;
        logic i_lt_span;
        logic start_hit;
        logic full;
        logic run_go;
        logic out_free;
        logic emit_last;
    } rsos_stat_t;

endpackage

// ===== hdl/rsos_ram.sv =====
// ---------------------------------------------------------------------------
// rsos_ram
// Generic single-clock RAM, one write port and one registered read port.
// ---------------------------------------------------------------------------
module rsos_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 128,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write, then register the read word
    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/rsos_ctrl.sv =====
// ---------------------------------------------------------------------------
// rsos_ctrl
// Sequencer: load, end markers, spike pass, object search and emission.
// ---------------------------------------------------------------------------
module rsos_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  rsos_pkg::rsos_stat_t status,
    output rsos_pkg::rsos_op_t   op
);
    import rsos_pkg::*;

    rsos_state_t state_reg;
    rsos_state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (status.final_fire) state_next = ST_EDGE;
            end
            ST_EDGE:     state_next = ST_SPK_CUR;
            ST_SPK_CUR:  state_next = ST_SPK_CHK;
            ST_SPK_CHK: begin
                state_next = status.i_lt_span ? ST_SPK_EX : ST_DET_INIT;
            end
            ST_SPK_EX:   state_next = ST_SPK_CHK;
            ST_DET_INIT: state_next = ST_DET_CUR;
            ST_DET_CUR:  state_next = ST_DET_CHK;
            ST_DET_CHK: begin
                if (!status.i_lt_span) begin
                    state_next = ST_EMIT_RD;
                end else if (status.start_hit) begin
                    state_next = status.full ? ST_EMIT_RD : ST_RUN_EX;
                end else begin
                    state_next = ST_DET_ADV;
                end
            end
            ST_DET_ADV:  state_next = ST_DET_CHK;
            ST_RUN_CHK: begin
                state_next = status.i_lt_span ? ST_RUN_EX : ST_MID;
            end
            ST_RUN_EX: begin
                state_next = status.run_go ? ST_RUN_CHK : ST_MID;
            end
            ST_MID:      state_next = ST_MID_CAP;
            ST_MID_CAP:  state_next = ST_DET_CHK;
            ST_EMIT_RD:  state_next = ST_EMIT_LD;
            ST_EMIT_LD: begin
                if (status.out_free) begin
                    state_next = status.emit_last ? ST_LOAD : ST_EMIT_RD;
                end
            end
            default:     state_next = ST_LOAD;
        endcase
    end

    // Command to the datapath
    always_comb begin
        unique case (state_reg)
            ST_LOAD:     op = OP_LOAD;
            ST_EDGE:     op = OP_EDGE;
            ST_SPK_CUR:  op = OP_SPK_CUR;
            ST_SPK_CHK:  op = OP_SPK_RD;
            ST_SPK_EX:   op = OP_SPK_EX;
            ST_DET_INIT: op = OP_DET_INIT;
            ST_DET_CUR:  op = OP_DET_CUR;
            ST_DET_CHK:  op = OP_DET_CHK;
            ST_DET_ADV:  op = OP_DET_ADV;
            ST_RUN_CHK:  op = OP_RUN_CHK;
            ST_RUN_EX:   op = OP_RUN_EX;
            ST_MID:      op = OP_MID;
            ST_MID_CAP:  op = OP_MID_CAP;
            ST_EMIT_RD:  op = OP_IDLE;
            ST_EMIT_LD:  op = OP_EMIT_LD;
            default:     op = OP_IDLE;
        endcase
    end

endmodule

// ===== hdl/rsos_datapath.sv =====
// ---------------------------------------------------------------------------
// rsos_datapath
// Sample store, sliding window over the sweep, object table and result
// register of the range scan object segmenter.
// ---------------------------------------------------------------------------
module rsos_datapath #(
    parameter int SCAN_DEPTH  = 128,
    parameter int MAX_OBJECTS = 10
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  rsos_pkg::rsos_cfg_t               cfg,
    input  rsos_pkg::rsos_op_t                op,
    output rsos_pkg::rsos_stat_t              status,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [rsos_pkg::SAMPLE_W-1:0]     s_sample_cm,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_object_found,
    output logic [rsos_pkg::ANGLE_W-1:0]      m_start_angle,
    output logic [rsos_pkg::ANGLE_W-1:0]      m_end_angle,
    output logic [rsos_pkg::SAMPLE_W-1:0]     m_distance_cm,
    output logic                              m_overflow,
    output logic                              m_last
);
    import rsos_pkg::*;

    localparam int AW    = $clog2(SCAN_DEPTH);
    localparam int IW    = AW + 1;
    localparam int OW    = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
    localparam int CW    = $clog2(MAX_OBJECTS + 1);
    localparam int OBJ_W = 2 * AW + SAMPLE_W;
    localparam int AGW   = (AW + 2 > 11) ? AW + 2 : 11;

    // Local angle index to heading, reduced into 0..359
    function automatic logic [ANGLE_W-1:0] to_heading(
        input logic [AW-1:0]      idx,
        input logic [AW-1:0]      span_v,
        input logic [ANGLE_W-1:0] hmod_v
    );
        logic [AGW-1:0] t;
        t = AGW'(hmod_v) + (AGW'(idx) << 1) + AGW'(DEG_FULL) - AGW'(span_v);
        if (t >= AGW'(2 * DEG_FULL)) begin
            t = t - AGW'(2 * DEG_FULL);
        end else if (t >= AGW'(DEG_FULL)) begin
            t = t - AGW'(DEG_FULL);
        end
        return ANGLE_W'(t);
    endfunction

    logic [AW-1:0]       span;
    logic [AW-1:0]       loaded_reg;
    logic [AW-1:0]       load_idx;
    logic                load_final;
    logic                in_fire;
    logic [12:0]         edge_sum;
    logic [SAMPLE_W-1:0] edge_cm;
    logic [ANGLE_W-1:0]  hmod;

    logic [IW-1:0]       i_reg;
    logic [IW-1:0]       i_plus1;
    logic [IW-1:0]       e_idx;
    logic [SAMPLE_W-1:0] prev_reg;
    logic [SAMPLE_W-1:0] cur_reg;
    logic [SAMPLE_W-1:0] nxt_reg;
    logic [AW-1:0]       start_reg;
    logic [CW-1:0]       total_reg;
    logic                over_reg;
    logic [CW-1:0]       k_reg;
    logic [IW-1:0]       mid_sum;
    logic [AW-1:0]       mid_idx;

    logic                st_we;
    logic [AW-1:0]       st_waddr;
    logic [SAMPLE_W-1:0] st_wdata;
    logic [AW-1:0]       st_raddr;
    logic [SAMPLE_W-1:0] st_rdata;

    logic [SAMPLE_W-1:0] d_cp;
    logic [SAMPLE_W-1:0] d_cn;
    logic                spike;
    logic [12:0]         mean_sum;
    logic [SAMPLE_W-1:0] mean;
    logic [15:0]         ten_cur;
    logic [15:0]         ratio_prev;
    logic [12:0]         next_margin;

    logic                obj_we;
    logic [OBJ_W-1:0]    obj_wdata;
    logic [OBJ_W-1:0]    obj_rdata;
    logic [AW-1:0]       obj_start;
    logic [AW-1:0]       obj_end;
    logic [SAMPLE_W-1:0] obj_dist;
    logic                total_zero;
    logic                emit_last;
    logic                out_free;
    logic                emit_load;

    logic                m_valid_reg;
    logic                found_reg;
    logic [ANGLE_W-1:0]  start_angle_reg;
    logic [ANGLE_W-1:0]  end_angle_reg;
    logic [SAMPLE_W-1:0] dist_reg;
    logic                overflow_reg;
    logic                last_reg;

    // Effective span, end marker and reduced heading
    assign span = (32'(cfg.scan_span) > 32'(SCAN_DEPTH - 1)) ? AW'(SCAN_DEPTH - 1)
                                                             : AW'(cfg.scan_span);
    assign edge_sum = {1'b0, cfg.far_limit_cm} + EDGE_PAD_CM;
    assign edge_cm  = edge_sum[12] ? SAMPLE_MAX : edge_sum[SAMPLE_W-1:0];
    assign hmod     = (cfg.heading_deg >= ANGLE_LIMIT) ? cfg.heading_deg - ANGLE_LIMIT
                                                       : cfg.heading_deg;

    // Load bookkeeping
    assign s_ready    = (op == OP_LOAD);
    assign in_fire    = s_valid && s_ready;
    assign load_idx   = (loaded_reg > span) ? span : loaded_reg;
    assign load_final = (loaded_reg >= span);

    // Window indexes
    assign i_plus1 = i_reg + IW'(1);
    assign e_idx   = i_reg - IW'(1);
    assign mid_sum = IW'(start_reg) + e_idx;
    assign mid_idx = mid_sum[AW:1];

    // Spike test on prev / cur / next
    assign d_cp     = (cur_reg > prev_reg) ? cur_reg - prev_reg : prev_reg - cur_reg;
    assign d_cn     = (cur_reg > st_rdata) ? cur_reg - st_rdata : st_rdata - cur_reg;
    assign spike    = (d_cp > cfg.spike_cm) && (d_cn > cfg.spike_cm);
    assign mean_sum = {1'b0, prev_reg} + {1'b0, st_rdata};
    assign mean     = mean_sum[12:1];

    // Object start and run tests
    assign ten_cur     = 16'({cur_reg, 3'b000}) + 16'({cur_reg, 1'b0});
    assign ratio_prev  = 16'(cfg.drop_ratio_tenths) * 16'(prev_reg);
    assign next_margin = {1'b0, st_rdata} + {1'b0, cfg.merge_margin_cm};

    // Sample store port steering
    always_comb begin
        st_we    = 1'b0;
        st_waddr = i_reg[AW-1:0];
        st_wdata = mean;
        st_raddr = i_plus1[AW-1:0];
        unique case (op)
            OP_LOAD: begin
                st_we    = in_fire;
                st_waddr = load_idx;
                st_wdata = load_final ? edge_cm : s_sample_cm;
            end
            OP_EDGE: begin
                st_we    = 1'b1;
                st_waddr = '0;
                st_wdata = edge_cm;
                st_raddr = AW'(1);
            end
            OP_SPK_EX: begin
                st_we = spike;
            end
            OP_DET_INIT: begin
                st_raddr = AW'(1);
            end
            OP_MID: begin
                st_raddr = mid_idx;
            end
            default: begin
                st_we = 1'b0;
            end
        endcase
    end

    rsos_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (SCAN_DEPTH)
    ) u_store (
        .clk   (aclk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    // Object table: start, end and distance per object
    assign obj_we    = (op == OP_MID_CAP);
    assign obj_wdata = {start_reg, e_idx[AW-1:0], st_rdata};

    rsos_ram #(
        .WIDTH (OBJ_W),
        .DEPTH (MAX_OBJECTS)
    ) u_objects (
        .clk   (aclk),
        .we    (obj_we),
        .waddr (total_reg[OW-1:0]),
        .wdata (obj_wdata),
        .raddr (k_reg[OW-1:0]),
        .rdata (obj_rdata)
    );

    assign obj_start = obj_rdata[OBJ_W-1 -: AW];
    assign obj_end   = obj_rdata[SAMPLE_W +: AW];
    assign obj_dist  = obj_rdata[SAMPLE_W-1:0];

    // Emission control
    assign total_zero = (total_reg == '0);
    assign emit_last  = total_zero || (CW'(k_reg + CW'(1)) == total_reg);
    assign out_free   = !m_valid_reg || m_ready;
    assign emit_load  = (op == OP_EMIT_LD) && out_free;

    // Status to the controller
    assign status.final_fire = in_fire && load_final;
    assign status.i_lt_span  = (i_reg < IW'(span));
    assign status.start_hit  = (ten_cur < ratio_prev) && (cur_reg < cfg.far_limit_cm);
    assign status.full       = (total_reg == CW'(MAX_OBJECTS));
    assign status.run_go     = (cur_reg < cfg.far_limit_cm) && ({1'b0, cur_reg} < next_margin);
    assign status.out_free   = out_free;
    assign status.emit_last  = emit_last;

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loaded_reg  <= '0;
            i_reg       <= '0;
            total_reg   <= '0;
            over_reg    <= 1'b0;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (in_fire) begin
                loaded_reg <= load_final ? '0 : load_idx + AW'(1);
            end
            case (op)
                OP_EDGE: begin
                    i_reg <= IW'(1);
                end
                OP_SPK_EX, OP_DET_ADV: begin
                    i_reg <= i_plus1;
                end
                OP_DET_INIT: begin
                    i_reg     <= IW'(1);
                    total_reg <= '0;
                    over_reg  <= 1'b0;
                    k_reg     <= '0;
                end
                OP_DET_CHK: begin
                    if (status.i_lt_span && status.start_hit && status.full) begin
                        over_reg <= 1'b1;
                    end
                end
                OP_RUN_EX: begin
                    if (status.run_go) begin
                        i_reg <= i_plus1;
                    end
                end
                OP_MID_CAP: begin
                    total_reg <= total_reg + CW'(1);
                    i_reg     <= i_plus1;
                end
                OP_EMIT_LD: begin
                    if (out_free) begin
                        k_reg <= k_reg + CW'(1);
                    end
                end
                default: begin
                end
            endcase
            // Hold the result until taken
            if (emit_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Window and result payload
    always_ff @(posedge aclk) begin
        case (op)
            OP_EDGE, OP_DET_INIT: begin
                prev_reg <= edge_cm;
            end
            OP_SPK_CUR, OP_DET_CUR: begin
                cur_reg <= st_rdata;
            end
            OP_SPK_EX: begin
                prev_reg <= spike ? mean : cur_reg;
                cur_reg  <= st_rdata;
            end
            OP_DET_CHK: begin
                start_reg <= i_reg[AW-1:0];
            end
            OP_DET_ADV: begin
                prev_reg <= cur_reg;
                cur_reg  <= st_rdata;
            end
            OP_RUN_EX: begin
                if (status.run_go) begin
                    prev_reg <= cur_reg;
                    cur_reg  <= st_rdata;
                end else begin
                    nxt_reg <= st_rdata;
                end
            end
            OP_MID_CAP: begin
                prev_reg <= cur_reg;
                cur_reg  <= nxt_reg;
            end
            default: begin
            end
        endcase
        if (emit_load) begin
            found_reg       <= !total_zero;
            start_angle_reg <= total_zero ? '0 : to_heading(obj_start, span, hmod);
            end_angle_reg   <= total_zero ? '0 : to_heading(obj_end, span, hmod);
            dist_reg        <= total_zero ? '0 : obj_dist;
            overflow_reg    <= over_reg && !total_zero;
            last_reg        <= emit_last;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_object_found = found_reg;
    assign m_start_angle  = start_angle_reg;
    assign m_end_angle    = end_angle_reg;
    assign m_distance_cm  = dist_reg;
    assign m_overflow     = overflow_reg;
    assign m_last         = last_reg;

endmodule

// ===== hdl/range_scan_object_segmenter.sv =====
// ---------------------------------------------------------------------------
// range_scan_object_segmenter
// Collects one sweep of range samples, removes spikes and reports objects.
// ---------------------------------------------------------------------------
// Usage:
//   s_ channel takes one range sample per item, in angle order. Each sample
//   that does not close the sweep is stored, and the next one can follow at
//   once. The sample at index scan_span closes the sweep.
//   After that sample the block stops taking items while it cleans and scans
//   the sample store, one store read per step of a single read port: first
//   the spike pass, then the object search with a midpoint read per object,
//   then one table read per result item. m_ channel delivers the objects in
//   angle order, or one empty item; m_last marks the final item of the sweep.
//   A stalled m_ side holds the result register and the sequencer; once the
//   final item sits in the register the block takes samples of the next
//   sweep again. Configuration is to be written over the APB port only
//   while no sweep is in flight; the block itself does not enforce this.
//   Reset returns the register defaults, empties the sample count and drops
//   any pending result. The store needs no clearing pass.
// ---------------------------------------------------------------------------
module range_scan_object_segmenter #(
    parameter int SCAN_DEPTH  = 128,
    parameter int MAX_OBJECTS = 10
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rsos_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [rsos_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [rsos_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready,
    // Sample input
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [rsos_pkg::SAMPLE_W-1:0]       s_sample_cm,
    // Object results
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_object_found,
    output logic [rsos_pkg::ANGLE_W-1:0]        m_start_angle,
    output logic [rsos_pkg::ANGLE_W-1:0]        m_end_angle,
    output logic [rsos_pkg::SAMPLE_W-1:0]       m_distance_cm,
    output logic                                m_overflow,
    output logic                                m_last
);
    import rsos_pkg::*;

    rsos_cfg_t  cfg_reg;
    rsos_op_t   dp_op;
    rsos_stat_t dp_status;
    logic       cfg_wr;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.scan_span         <= RST_SCAN_SPAN;
            cfg_reg.far_limit_cm      <= RST_FAR_LIMIT;
            cfg_reg.spike_cm          <= RST_SPIKE;
            cfg_reg.drop_ratio_tenths <= RST_DROP_RATIO;
            cfg_reg.merge_margin_cm   <= RST_MARGIN;
            cfg_reg.heading_deg       <= RST_HEADING;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_SCAN_SPAN:  cfg_reg.scan_span         <= pwdata[SPAN_W-1:0];
                REG_FAR_LIMIT:  cfg_reg.far_limit_cm      <= pwdata[SAMPLE_W-1:0];
                REG_SPIKE:      cfg_reg.spike_cm          <= pwdata[SAMPLE_W-1:0];
                REG_DROP_RATIO: cfg_reg.drop_ratio_tenths <= pwdata[RATIO_W-1:0];
                REG_MARGIN:     cfg_reg.merge_margin_cm   <= pwdata[SAMPLE_W-1:0];
                REG_HEADING:    cfg_reg.heading_deg       <= pwdata[ANGLE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Register reads
    always_comb begin
        unique case (reg_idx)
            REG_SCAN_SPAN:  prdata = CFG_DATA_W'(cfg_reg.scan_span);
            REG_FAR_LIMIT:  prdata = CFG_DATA_W'(cfg_reg.far_limit_cm);
            REG_SPIKE:      prdata = CFG_DATA_W'(cfg_reg.spike_cm);
            REG_DROP_RATIO: prdata = CFG_DATA_W'(cfg_reg.drop_ratio_tenths);
            REG_MARGIN:     prdata = CFG_DATA_W'(cfg_reg.merge_margin_cm);
            REG_HEADING:    prdata = CFG_DATA_W'(cfg_reg.heading_deg);
            default:        prdata = '0;
        endcase
    end

    rsos_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (dp_status),
        .op      (dp_op)
    );

    rsos_datapath #(
        .SCAN_DEPTH  (SCAN_DEPTH),
        .MAX_OBJECTS (MAX_OBJECTS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .op             (dp_op),
        .status         (dp_status),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample_cm    (s_sample_cm),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_object_found (m_object_found),
        .m_start_angle  (m_start_angle),
        .m_end_angle    (m_end_angle),
        .m_distance_cm  (m_distance_cm),
        .m_overflow     (m_overflow),
        .m_last         (m_last)
    );

`include "range_scan_object_segmenter_assert.svh"

    // An empty report closes the sweep and never flags overflow
    `RSOS_ASSERT_IMP(a_empty_last, m_valid && !m_object_found, m_last && !m_overflow, "bad empty item")
    // Reported angles are reduced into one turn
    `RSOS_ASSERT_IMP(a_start_range, m_valid, m_start_angle < ANGLE_LIMIT, "start angle too big")
    `RSOS_ASSERT_IMP(a_end_range, m_valid, m_end_angle < ANGLE_LIMIT, "end angle too big")
    // Closing sample stops intake while the sweep is processed
    `RSOS_ASSERT_NXT(a_close_stops_intake, dp_status.final_fire, !s_ready, "intake open after close")

endmodule

// ===== tb/scan_result_checker.sv =====
// ---------------------------------------------------------------------------
// scan_result_checker
// Watches the configuration port and both item channels of the range scan
// object segmenter. It keeps its own copy of the registers and of the sample
// store, works out the object list of each completed sweep, and compares
// every delivered result item field by field with the oldest one due.
// ---------------------------------------------------------------------------
module scan_result_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic                            pready,
    input  logic [rsos_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [rsos_pkg::CFG_DATA_W-1:0] pwdata,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic [rsos_pkg::SAMPLE_W-1:0]   s_sample_cm,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic                            m_object_found,
    input  logic [rsos_pkg::ANGLE_W-1:0]    m_start_angle,
    input  logic [rsos_pkg::ANGLE_W-1:0]    m_end_angle,
    input  logic [rsos_pkg::SAMPLE_W-1:0]   m_distance_cm,
    input  logic                            m_overflow,
    input  logic                            m_last,
    output int                              fail_count,
    output int                              pending
);
    import rsos_pkg::*;

    localparam int STORE_DEPTH  = 128;
    localparam int OBJECT_LIMIT = 10;

    typedef struct packed {
        logic                object_found;
        logic [ANGLE_W-1:0]  start_angle;
        logic [ANGLE_W-1:0]  end_angle;
        logic [SAMPLE_W-1:0] distance_cm;
        logic                overflow;
        logic                last;
    } scan_object_t;

    rsos_cfg_t           cfg;
    logic [SAMPLE_W-1:0] sweep_samples [STORE_DEPTH];
    int                  samples_held;
    scan_object_t        objects_due [$];
    int                  errors = 0;

    task automatic report(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        errors++;
    endtask

    // Local index to heading-relative angle, reduced modulo a full turn
    function automatic int angle_of(input int idx, input int span);
        return (2 * idx + int'(cfg.heading_deg) + 720 - span) % DEG_FULL;
    endfunction

    // Clean the finished sweep, find objects and queue the result items
    task automatic segment_sweep(input int span);
        int           marker_cm, i, k, p, c, n, s, e, total;
        bit           crowded;
        int           starts [OBJECT_LIMIT];
        int           ends   [OBJECT_LIMIT];
        int           dists  [OBJECT_LIMIT];
        scan_object_t item;

        // force both ends to the far marker, saturating at the sample width
        marker_cm = int'(cfg.far_limit_cm) + 50;
        if (marker_cm > 4095) marker_cm = 4095;
        sweep_samples[0]    = SAMPLE_W'(marker_cm);
        sweep_samples[span] = SAMPLE_W'(marker_cm);

        // replace isolated spikes in place, left to right
        for (i = 1; i < span; i++) begin
            p = sweep_samples[i-1];
            c = sweep_samples[i];
            n = sweep_samples[i+1];
            if (((c > p) ? c - p : p - c) > int'(cfg.spike_cm) &&
                ((c > n) ? c - n : n - c) > int'(cfg.spike_cm)) begin
                sweep_samples[i] = SAMPLE_W'((p + n) >> 1);
            end
        end

        // find object runs; stop when one more would not fit
        total   = 0;
        crowded = 1'b0;
        i       = 1;
        while (i < span) begin
            c = sweep_samples[i];
            if (10 * c < int'(cfg.drop_ratio_tenths) * int'(sweep_samples[i-1]) &&
                c < int'(cfg.far_limit_cm)) begin
                if (total >= OBJECT_LIMIT) begin
                    crowded = 1'b1;
                    break;
                end
                s = i;
                while (i < span && int'(sweep_samples[i]) < int'(cfg.far_limit_cm) &&
                       int'(sweep_samples[i]) <
                       int'(sweep_samples[i+1]) + int'(cfg.merge_margin_cm)) begin
                    i++;
                end
                e = i - 1;
                starts[total] = s;
                ends[total]   = e;
                dists[total]  = sweep_samples[(s + e) >> 1];
                total++;
            end
            i++;
        end

        // one empty item, or one item per object
        if (total == 0) begin
            item      = '0;
            item.last = 1'b1;
            objects_due.push_back(item);
        end else begin
            for (k = 0; k < total; k++) begin
                item.object_found = 1'b1;
                item.start_angle  = ANGLE_W'(angle_of(starts[k], span));
                item.end_angle    = ANGLE_W'(angle_of(ends[k], span));
                item.distance_cm  = SAMPLE_W'(dists[k]);
                item.overflow     = crowded;
                item.last         = (k + 1 == total);
                objects_due.push_back(item);
            end
        end
    endtask

    // Store one accepted sample; the one at the span index closes the sweep
    task automatic absorb_sample(input logic [SAMPLE_W-1:0] value);
        int span, slot;
        span = (int'(cfg.scan_span) > STORE_DEPTH - 1) ? STORE_DEPTH - 1 : int'(cfg.scan_span);
        slot = (samples_held > span) ? span : samples_held;
        sweep_samples[slot] = value;
        if (slot < span) begin
            samples_held = slot + 1;
        end else begin
            samples_held = 0;
            segment_sweep(span);
        end
    endtask

    // Compare one delivered item with the oldest one due
    task automatic check_result();
        scan_object_t want;
        if (objects_due.size() == 0) begin
            report($sformatf("result item with none due (found %0d, last %0d)",
                             m_object_found, m_last));
            return;
        end
        want = objects_due.pop_front();
        if (m_object_found !== want.object_found)
            report($sformatf("object_found got %0d, want %0d", m_object_found, want.object_found));
        if (m_start_angle !== want.start_angle)
            report($sformatf("start_angle got %0d, want %0d", m_start_angle, want.start_angle));
        if (m_end_angle !== want.end_angle)
            report($sformatf("end_angle got %0d, want %0d", m_end_angle, want.end_angle));
        if (m_distance_cm !== want.distance_cm)
            report($sformatf("distance_cm got %0d, want %0d", m_distance_cm, want.distance_cm));
        if (m_overflow !== want.overflow)
            report($sformatf("overflow got %0d, want %0d", m_overflow, want.overflow));
        if (m_last !== want.last)
            report($sformatf("last got %0d, want %0d", m_last, want.last));
    endtask

    // Follow register writes and both channels at every clock edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg = '{scan_span:         RST_SCAN_SPAN,
                    far_limit_cm:      RST_FAR_LIMIT,
                    spike_cm:          RST_SPIKE,
                    drop_ratio_tenths: RST_DROP_RATIO,
                    merge_margin_cm:   RST_MARGIN,
                    heading_deg:       RST_HEADING};
            samples_held = 0;
            objects_due.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[CFG_ADDR_W-1:2])
                    REG_SCAN_SPAN:  cfg.scan_span         = pwdata[SPAN_W-1:0];
                    REG_FAR_LIMIT:  cfg.far_limit_cm      = pwdata[SAMPLE_W-1:0];
                    REG_SPIKE:      cfg.spike_cm          = pwdata[SAMPLE_W-1:0];
                    REG_DROP_RATIO: cfg.drop_ratio_tenths = pwdata[RATIO_W-1:0];
                    REG_MARGIN:     cfg.merge_margin_cm   = pwdata[SAMPLE_W-1:0];
                    REG_HEADING:    cfg.heading_deg       = pwdata[ANGLE_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) check_result();
            if (s_valid && s_ready) absorb_sample(s_sample_cm);
        end
        fail_count <= errors;
        pending    <= objects_due.size();
    end

endmodule

// ===== tb/range_scan_object_segmenter_tb.sv =====
// ---------------------------------------------------------------------------
// range_scan_object_segmenter_tb
// Drives sweeps of range samples into the segmenter under changing register
// settings: a short hand-made set of corner sweeps first, then random sweeps
// shaped as background with dips, crowded object combs and plain noise.
// Both channels are paced at random, and once the result side holds off long
// enough to back up the sample input. The checker beside the block predicts
// and compares; this module only makes stimulus and gives the verdict.
// ---------------------------------------------------------------------------
module range_scan_object_segmenter_tb;
    import rsos_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 500;
    localparam int RANDOM_ITEMS  = 80;

    typedef enum int {
        SHAPE_OBJECTS,
        SHAPE_CROWDED,
        SHAPE_NOISE
    } sweep_shape_t;

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr   = '0;
    logic [CFG_DATA_W-1:0] pwdata  = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    logic [SAMPLE_W-1:0]   s_sample_cm = '0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    logic                  m_object_found;
    logic [ANGLE_W-1:0]    m_start_angle;
    logic [ANGLE_W-1:0]    m_end_angle;
    logic [SAMPLE_W-1:0]   m_distance_cm;
    logic                  m_overflow;
    logic                  m_last;

    int                    fail_count;
    int                    pending;
    int                    cycle_count   = 0;
    int                    random_items  = 0;
    int                    send_idle_pct = 19;
    int                    recv_idle_pct = 56;
    int                    hold_left     = 0;
    bit                    hold_request  = 1'b0;
    int                    cur_span      = 90;
    int                    cur_far       = 100;
    logic [SAMPLE_W-1:0]   sweep_buf [128];

    always #2 aclk = ~aclk;

    range_scan_object_segmenter uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample_cm    (s_sample_cm),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_object_found (m_object_found),
        .m_start_angle  (m_start_angle),
        .m_end_angle    (m_end_angle),
        .m_distance_cm  (m_distance_cm),
        .m_overflow     (m_overflow),
        .m_last         (m_last)
    );

    scan_result_checker result_monitor (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample_cm    (s_sample_cm),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_object_found (m_object_found),
        .m_start_angle  (m_start_angle),
        .m_end_angle    (m_end_angle),
        .m_distance_cm  (m_distance_cm),
        .m_overflow     (m_overflow),
        .m_last         (m_last),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    // Count cycles
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // Give up when the run hangs
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // Result side: random stalls, or one long hold-off once requested
    initial begin
        bit hold_taken;
        hold_taken = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    function automatic int pick(input int lo, input int hi, input int floor_v, input int ceil_v);
        case ($urandom_range(0, 7))
            0:       return floor_v;
            1:       return ceil_v;
            default: return $urandom_range(lo, hi);
        endcase
    endfunction

    // Setup cycle then access cycle; psel stays up across back-to-back writes
    task automatic write_reg(input logic [2:0] index, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
    endtask

    task automatic load_config(input int span, input int far, input int spike,
                               input int ratio, input int margin, input int heading);
        write_reg(REG_SCAN_SPAN, span);
        write_reg(REG_FAR_LIMIT, far);
        write_reg(REG_SPIKE, spike);
        write_reg(REG_DROP_RATIO, ratio);
        write_reg(REG_MARGIN, margin);
        write_reg(REG_HEADING, heading);
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        cur_span = span;
        cur_far  = far;
    endtask

    // Offer one sample, idling first at random, and hold it until accepted
    task automatic push_sample(input int value);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_sample_cm <= SAMPLE_W'(value);
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_sweep(input int span);
        int i;
        for (i = 0; i <= span; i++) push_sample(sweep_buf[i]);
        random_items += span + 1;
    endtask

    // Wait until every result is in, then let the block settle
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4 * cur_span + 80) @(posedge aclk);
    endtask

    // Fill the sweep buffer with a profile of the given shape
    task automatic build_sweep(input sweep_shape_t shape, input int span);
        int bg, near, i, w, k;
        int fl;
        fl = (cur_far < 2) ? 2 : cur_far;
        bg = cur_far + $urandom_range(0, 400);
        if (bg > 4000) bg = 4000;
        i = 0;
        while (i <= span) begin
            case (shape)
                SHAPE_NOISE: begin
                    sweep_buf[i] = SAMPLE_W'($urandom_range(0, 4000));
                    i++;
                end
                SHAPE_CROWDED: begin
                    // two background samples, then two near hits
                    near = $urandom_range(0, fl / 4);
                    for (k = 0; k < 2 && i <= span; k++) begin
                        sweep_buf[i] = SAMPLE_W'(bg);
                        i++;
                    end
                    for (k = 0; k < 2 && i <= span; k++) begin
                        sweep_buf[i] = SAMPLE_W'(near + $urandom_range(0, 3));
                        i++;
                    end
                end
                default: begin
                    if ($urandom_range(0, 2) == 0) begin
                        near = $urandom_range(0, fl - 1) / 2;
                        w    = $urandom_range(1, 6);
                        for (k = 0; k < w && i <= span; k++) begin
                            sweep_buf[i] = SAMPLE_W'(near + $urandom_range(0, 8) * k);
                            i++;
                        end
                    end else begin
                        sweep_buf[i] = SAMPLE_W'(bg - $urandom_range(0, 20));
                        i++;
                    end
                    // drop in an occasional lone spike
                    if ($urandom_range(0, 15) == 0)
                        sweep_buf[i-1] = SAMPLE_W'($urandom_range(0, 4000));
                end
            endcase
        end
    endtask

    initial begin
        int           phase_no, sweeps, k, span;
        sweep_shape_t shape;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Corner sweeps: object found, spike cleaned, extremes of samples
        load_config(4, 100, 30, 7, 15, 90);
        push_sample(4000); push_sample(40); push_sample(45); push_sample(50); push_sample(0);
        push_sample(0); push_sample(200); push_sample(4000); push_sample(200); push_sample(4000);
        drain();
        // one-sample sweep, saturated end marker, heading past a full turn
        load_config(0, 4095, 0, 0, 0, 511);
        push_sample(4000);
        drain();
        // run that stops at once, so it ends before it starts
        load_config(3, 4000, 4095, 10, 0, 0);
        push_sample(0); push_sample(10); push_sample(10); push_sample(0);
        drain();
        // widest ratio and margin, heading just short of a full turn
        load_config(2, 1, 0, 15, 4095, 359);
        push_sample(0); push_sample(0); push_sample(0);
        drain();
        // zero far limit finds nothing
        load_config(2, 0, 0, 15, 4095, 359);
        push_sample(0); push_sample(0); push_sample(0);
        drain();
        // zero ratio starts nothing
        load_config(3, 4000, 0, 0, 15, 180);
        push_sample(0); push_sample(5); push_sample(5); push_sample(0);
        drain();

        // Random phases: pacing moves from sender-light to receiver-light to none
        phase_no = 0;
        while ((phase_no < 6 || random_items < RANDOM_ITEMS) && phase_no < 12) begin
            if (phase_no < 2) begin
                send_idle_pct = 19;
                recv_idle_pct = 56;
            end else if (phase_no < 4) begin
                send_idle_pct = 56;
                recv_idle_pct = 19;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            if (phase_no == 1) begin
                // dense comb of objects, enough to run past the object limit
                span   = $urandom_range(44, 48);
                sweeps = 1;
                load_config(span, $urandom_range(200, 2000), $urandom_range(10, 200),
                            $urandom_range(6, 10), $urandom_range(0, 30),
                            pick(0, 359, 0, 511));
            end else begin
                span   = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 10);
                sweeps = (phase_no == 3) ? 3 : 1;
                load_config(span, pick(20, 1500, 0, 4095), pick(5, 200, 0, 4095),
                            pick(4, 10, 0, 15), pick(0, 60, 0, 4095), pick(0, 359, 0, 511));
            end

            // hold off the result side so the block backs up its input
            if (phase_no == 3) hold_request = 1'b1;

            for (k = 0; k < sweeps; k++) begin
                if (phase_no == 1)
                    shape = SHAPE_CROWDED;
                else if ($urandom_range(0, 4) == 0)
                    shape = SHAPE_NOISE;
                else
                    shape = SHAPE_OBJECTS;
                build_sweep(shape, span);
                send_sweep(span);
            end
            drain();
            phase_no++;
        end

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== range_scan_object_segmenter.f =====
+incdir+hdl
hdl/rsos_pkg.sv
hdl/rsos_ram.sv
hdl/rsos_ctrl.sv
hdl/rsos_datapath.sv
hdl/range_scan_object_segmenter.sv
tb/scan_result_checker.sv
tb/range_scan_object_segmenter_tb.sv
